// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HISU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge
`define HISU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hisu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hisu_pkg
// Shared constants, register map and control types of the inlier scorer.
// ----------------------------------------------------------------------------
package hisu_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COUNT_W    = 13;
  localparam int SUM_W      = 48;
  localparam int RES_W      = 32;
  localparam int ACC_W      = 50;
  localparam int QUO_W      = 40;
  localparam int DIV_STEPS  = 40;
  localparam int ADDR_W     = 6;
  localparam int CFG_W      = 64;

  localparam int COUNT_CAP_I = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_CAP_I[COUNT_W-1:0];
  localparam logic [RES_W-1:0]   RES_MAX   = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  typedef enum logic [2:0] {
    REG_ROW0_AB  = 3'd0,
    REG_H02_H10  = 3'd1,
    REG_H11_H12  = 3'd2,
    REG_PERSP    = 3'd3,
    REG_H22      = 3'd4,
    REG_MAX_RES  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] row0_ab;
    logic [63:0] h02_h10;
    logic [63:0] h11_h12;
    logic [63:0] persp;
    logic [31:0] h22;
    logic [31:0] max_res;
  } coef_t;

  typedef struct packed {
    logic       load;
    logic       prod_en;
    logic [2:0] prod_idx;
    logic       acc_en;
    logic [2:0] acc_idx;
    logic       div_start;
    logic       diff_en;
    logic       sq_en;
    logic       fin_en;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hisu_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hisu_in_if
// Correspondence word channel.
// ----------------------------------------------------------------------------
interface hisu_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] src_x;
  logic signed [15:0] src_y;
  logic signed [15:0] dst_x;
  logic signed [15:0] dst_y;
  logic               last_point;

  modport source (output valid, src_x, src_y, dst_x, dst_y, last_point, input ready);
  modport sink   (input valid, src_x, src_y, dst_x, dst_y, last_point, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hisu_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hisu_out_if
// Score result word channel.
// ----------------------------------------------------------------------------
interface hisu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] residual;
  logic        is_inlier;
  logic [12:0] inlier_count;
  logic [47:0] residual_sum;
  logic        set_done;

  modport source (output valid, residual, is_inlier, inlier_count, residual_sum, set_done,
                  input ready);
  modport sink   (input valid, residual, is_inlier, inlier_count, residual_sum, set_done,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hisu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hisu_div
// Restoring divider, one quotient bit per cycle: floor(n * 2^16 / d).
// ----------------------------------------------------------------------------
module hisu_div
  import hisu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [ACC_W-1:0]  num,
  input  wire logic [ACC_W-1:0]  den,
  output logic                   busy,
  output logic                   ovf,
  output logic [QUO_W-1:0]       quo
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] rem_r;
  logic [QUO_W-1:0] sh_r;
  logic [QUO_W-1:0] quo_r;
  logic [ACC_W-1:0] den_r;
  logic             ovf_r;
  logic [ACC_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, sh_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {(ACC_W - 26)'(0), num[ACC_W-1:24]};
      sh_r  <= {num[23:0], 16'b0};
      quo_r <= '0;
      den_r <= den;
      ovf_r <= {24'b0, num} >= {den, 24'b0};
    end else if (cnt_r != '0) begin
      rem_r <= ge ? ACC_W'(trial - {1'b0, den_r}) : trial[ACC_W-1:0];
      sh_r  <= {sh_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign busy = cnt_r != '0;
  assign ovf  = ovf_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/hisu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hisu_dp
// Datapath: shared MAC for the projection, two dividers, residual and totals.
// ----------------------------------------------------------------------------
module hisu_dp
  import hisu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire coef_t              coef,
  input  wire logic signed [15:0] src_x,
  input  wire logic signed [15:0] src_y,
  input  wire logic signed [15:0] dst_x,
  input  wire logic signed [15:0] dst_y,
  input  wire logic               last_point,
  output logic [RES_W-1:0]        residual,
  output logic                    is_inlier,
  output logic [COUNT_W-1:0]      inlier_count,
  output logic [SUM_W-1:0]        residual_sum,
  output logic                    set_done
);

  logic signed [15:0]      sx_r, sy_r, dx_r, dy_r;
  logic                    last_r;
  logic signed [ACC_W-1:0] n0_r, n1_r, dn_r;
  logic signed [47:0]      prod_r;
  logic signed [31:0]      mul_a;
  logic signed [15:0]      mul_b;
  logic signed [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0]        n0_mag, n1_mag, dn_mag;
  logic                    busy_x, busy_y, ovf_x, ovf_y;
  logic [QUO_W-1:0]        quo_x, quo_y;
  logic signed [41:0]      px, py, ex, ey;
  logic [41:0]             ax, ay;
  logic [16:0]             ax_r, ay_r;
  logic                    bad_r, zero_r;
  logic [33:0]             sqx_r, sqy_r;
  logic                    bad2_r, zero2_r;
  logic [34:0]             ssum;
  logic [RES_W-1:0]        res;
  logic                    inl;
  logic [SUM_W:0]          sum_add;
  logic [COUNT_W-1:0]      cnt_new;
  logic [SUM_W-1:0]        sum_new;
  logic [COUNT_W-1:0]      cnt_acc_r;
  logic [SUM_W-1:0]        sum_acc_r;
  logic [RES_W-1:0]        res_r;
  logic                    inl_r, done_r;

  always_comb begin
    case (cmd.prod_idx)
      3'd0:    mul_a = coef.row0_ab[63:32];
      3'd1:    mul_a = coef.row0_ab[31:0];
      3'd2:    mul_a = coef.h02_h10[31:0];
      3'd3:    mul_a = coef.h11_h12[63:32];
      3'd4:    mul_a = coef.persp[63:32];
      default: mul_a = coef.persp[31:0];
    endcase
    mul_b = cmd.prod_idx[0] ? sy_r : sx_r;
  end

  assign prod_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r   <= src_x;
      sy_r   <= src_y;
      dx_r   <= dst_x;
      dy_r   <= dst_y;
      last_r <= last_point;
      n0_r   <= {{2{coef.h02_h10[63]}}, coef.h02_h10[63:32], 16'b0};
      n1_r   <= {{2{coef.h11_h12[31]}}, coef.h11_h12[31:0], 16'b0};
      dn_r   <= {{2{coef.h22[31]}}, coef.h22, 16'b0};
    end else if (cmd.acc_en) begin
      case (cmd.acc_idx[2:1])
        2'd0:    n0_r <= n0_r + prod_ext;
        2'd1:    n1_r <= n1_r + prod_ext;
        default: dn_r <= dn_r + prod_ext;
      endcase
    end
    if (cmd.prod_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  assign n0_mag = n0_r[ACC_W-1] ? ACC_W'(-n0_r) : n0_r;
  assign n1_mag = n1_r[ACC_W-1] ? ACC_W'(-n1_r) : n1_r;
  assign dn_mag = dn_r[ACC_W-1] ? ACC_W'(-dn_r) : dn_r;

  hisu_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(n0_mag), .den(dn_mag), .busy(busy_x), .ovf(ovf_x), .quo(quo_x)
  );

  hisu_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(n1_mag), .den(dn_mag), .busy(busy_y), .ovf(ovf_y), .quo(quo_y)
  );

  assign status.div_busy = busy_x | busy_y;

  assign px = (n0_r[ACC_W-1] ^ dn_r[ACC_W-1]) ? -$signed({2'b0, quo_x}) : $signed({2'b0, quo_x});
  assign py = (n1_r[ACC_W-1] ^ dn_r[ACC_W-1]) ? -$signed({2'b0, quo_y}) : $signed({2'b0, quo_y});
  assign ex = 42'(dx_r) - px;
  assign ey = 42'(dy_r) - py;
  assign ax = ex[41] ? 42'(-ex) : ex;
  assign ay = ey[41] ? 42'(-ey) : ey;

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      ax_r   <= ax[16:0];
      ay_r   <= ay[16:0];
      zero_r <= dn_r == '0;
      bad_r  <= ovf_x | ovf_y | (|ax[41:17]) | (|ay[41:17]);
    end
    if (cmd.sq_en) begin
      sqx_r   <= ax_r * ax_r;
      sqy_r   <= ay_r * ay_r;
      bad2_r  <= bad_r | zero_r;
      zero2_r <= zero_r;
    end
  end

  assign ssum    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign res     = (bad2_r || (|ssum[34:32])) ? RES_MAX : ssum[31:0];
  assign inl     = !zero2_r && (res <= coef.max_res);
  assign sum_add = {1'b0, sum_acc_r} + {17'b0, res};
  assign cnt_new = (inl && cnt_acc_r < COUNT_CAP) ? cnt_acc_r + 1'b1 : cnt_acc_r;
  assign sum_new = !inl ? sum_acc_r : (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_acc_r <= '0;
      sum_acc_r <= '0;
    end else if (cmd.fin_en) begin
      cnt_acc_r <= last_r ? '0 : cnt_new;
      sum_acc_r <= last_r ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      res_r        <= res;
      inl_r        <= inl;
      inlier_count <= cnt_new;
      residual_sum <= sum_new;
      done_r       <= last_r;
    end
  end

  assign residual  = res_r;
  assign is_inlier = inl_r;
  assign set_done  = done_r;

endmodule
`default_nettype wire

// ===== hw/rtl/hisu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hisu_ctrl
// Sequencer: MAC steps, divide, residual, totals and result handshake.
// ----------------------------------------------------------------------------
module hisu_ctrl
  import hisu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DSTART, S_DWAIT, S_DIFF, S_SQ, S_FIN, S_OUT
  } state_t;

  localparam logic [2:0] MAC_LAST = 3'd6;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = S_MUL;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MAC_LAST) state_nxt = S_DSTART;
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (!status.div_busy) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_SQ;
      S_SQ:     state_nxt = S_FIN;
      S_FIN:    state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.prod_en   = (state_r == S_MUL) && (cnt_r != MAC_LAST);
    cmd.prod_idx  = cnt_r;
    cmd.acc_en    = (state_r == S_MUL) && (cnt_r != '0);
    cmd.acc_idx   = cnt_r - 1'b1;
    cmd.div_start = state_r == S_DSTART;
    cmd.diff_en   = (state_r == S_DWAIT) && !status.div_busy;
    cmd.sq_en     = state_r == S_DIFF;
    cmd.fin_en    = state_r == S_SQ;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

endmodule
`default_nettype wire

// ===== hw/rtl/homography_inlier_scoring_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homography_inlier_scoring_unit
// Projects point correspondences through a homography and scores inliers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one correspondence word (src/dst in Q12.4, last_point).
//   out_ch returns one score word per input: residual (Q24.8), is_inlier,
//   running inlier_count and residual_sum, set_done on the last point.
//   The APB port holds the homography and threshold at 8-byte steps.
// Sequence:
//   One word at a time. After accept the sequencer runs the shared
//   multiply-accumulate, then the two bit-serial dividers (start, one
//   quotient bit a cycle, capture), then the residual and totals steps.
//   A new word is accepted only after the result word has been taken.
// Reset:
//   Synchronous rst_n loads the identity homography, threshold 16.0, and
//   clears the totals. Totals also clear after the set_done word.
// Stall:
//   The result holds on out_ch until taken; in_ch stays not ready meanwhile.
// ----------------------------------------------------------------------------
module homography_inlier_scoring_unit
  import hisu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  hisu_in_if.sink                in_ch,
  hisu_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]       prdata,
  output logic                   pready
);

  coef_t    coef_r;
  cmd_t     cmd;
  status_t  status;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.row0_ab <= 64'h0100_0000_0000_0000;
      coef_r.h02_h10 <= '0;
      coef_r.h11_h12 <= 64'h0100_0000_0000_0000;
      coef_r.persp   <= '0;
      coef_r.h22     <= 32'h0100_0000;
      coef_r.max_res <= 32'd4096;
    end else if (wr_en) begin
      case (idx)
        REG_ROW0_AB: coef_r.row0_ab <= pwdata;
        REG_H02_H10: coef_r.h02_h10 <= pwdata;
        REG_H11_H12: coef_r.h11_h12 <= pwdata;
        REG_PERSP:   coef_r.persp   <= pwdata;
        REG_H22:     coef_r.h22     <= pwdata[31:0];
        REG_MAX_RES: coef_r.max_res <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW0_AB: prdata = coef_r.row0_ab;
      REG_H02_H10: prdata = coef_r.h02_h10;
      REG_H11_H12: prdata = coef_r.h11_h12;
      REG_PERSP:   prdata = coef_r.persp;
      REG_H22:     prdata = {32'b0, coef_r.h22};
      REG_MAX_RES: prdata = {32'b0, coef_r.max_res};
      default:     prdata = '0;
    endcase
  end

  hisu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd)
  );

  hisu_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .coef(coef_r),
    .src_x(in_ch.src_x), .src_y(in_ch.src_y),
    .dst_x(in_ch.dst_x), .dst_y(in_ch.dst_y), .last_point(in_ch.last_point),
    .residual(out_ch.residual), .is_inlier(out_ch.is_inlier),
    .inlier_count(out_ch.inlier_count), .residual_sum(out_ch.residual_sum),
    .set_done(out_ch.set_done)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/hisu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hisu_checker
// Port-level checks on the scorer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hisu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_inlier,
  input wire logic [12:0] inlier_count,
  input wire logic [31:0] residual
);

  `HISU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(residual), "result word dropped or changed while stalled")
  `HISU_ASSERT(a_no_overlap, clk, rst_n, out_valid |-> !in_ready, "input taken while a result is pending")
  `HISU_ASSERT(a_accept_gap, clk, rst_n, in_valid && in_ready |=> !out_valid, "result appeared right after accept")
  `HISU_ASSERT(a_inlier_count, clk, rst_n, out_valid && is_inlier |-> inlier_count != 13'd0, "inlier reported with zero count")
  `HISU_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind homography_inlier_scoring_unit hisu_checker u_hisu_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .is_inlier(out_ch.is_inlier), .inlier_count(out_ch.inlier_count),
  .residual(out_ch.residual)
);
`default_nettype wire
